// ----- rtl/core/piq_pkg.sv -----
// Package for the point-in-quad test unit: default widths, register
// indexes and the stage-advance struct shared by the datapath modules.
// No dependencies.
package piq_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int NUM_CORNERS     = 4;
  localparam int NUM_TRIS        = 6;   // four point triangles, two quad halves
  localparam int CFG_IDX_WIDTH   = 3;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_C0X = 3'd0,
    REG_C0Y = 3'd1,
    REG_C1X = 3'd2,
    REG_C1Y = 3'd3,
    REG_C2X = 3'd4,
    REG_C2Y = 3'd5,
    REG_C3X = 3'd6,
    REG_C3Y = 3'd7
  } cfg_reg_t;

  // Load enables for the two stages inside a triangle-area slice.
  typedef struct packed {
    logic s2;
    logic s3;
  } piq_adv_t;

endpackage

// ----- rtl/core/piq_tri.sv -----
// One doubled-triangle-area slice: two products, then |difference|.
// Two register stages; depends on piq_pkg for the advance struct.
module piq_tri import piq_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  localparam int DW = COORD_WIDTH + 1,
  localparam int PW = 2 * DW,
  localparam int AW = PW + 1
) (
  input  logic                 clk,
  input  piq_adv_t             adv,
  input  logic signed [DW-1:0] e_dx,
  input  logic signed [DW-1:0] p_dy,
  input  logic signed [DW-1:0] e_dy,
  input  logic signed [DW-1:0] p_dx,
  output logic        [AW-1:0] area
);

  logic signed [PW-1:0] t1_r, t2_r;
  logic signed [PW-1:0] t1_nxt, t2_nxt;
  logic signed [AW-1:0] cross_v;
  logic        [AW-1:0] area_r, area_nxt;

  assign t1_nxt = PW'(e_dx) * PW'(p_dy);
  assign t2_nxt = PW'(e_dy) * PW'(p_dx);

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      t1_r <= t1_nxt;
      t2_r <= t2_nxt;
    end
  end

  always_comb begin
    cross_v  = AW'(t1_r) - AW'(t2_r);
    area_nxt = cross_v[AW-1] ? AW'(-cross_v) : AW'(cross_v);
  end

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      area_r <= area_nxt;
    end
  end

  assign area = area_r;

endmodule

// ----- rtl/core/point_in_quad_test_unit.sv -----
// Top level of the point-in-quad test unit: corner registers, pipeline
// control, degenerate-quad tests and the area compare. Uses piq_pkg, piq_tri.
//
// Usage:
//   Write the four corners through cfg_we/cfg_index/cfg_wdata while no item
//   is in flight (index 0..7: c0x, c0y, c1x, c1y, c2x, c2y, c3x, c3y).
//   Send query points on in_valid/in_ready; each point yields one item on
//   out_valid/out_ready carrying out_inside_res (1 = inside or on the quad).
//   Five register stages: stage 1 forms the coordinate differences and the
//   degenerate tests, stage 2 the products, stage 3 the absolute cross
//   products, stage 4 pairwise sums, stage 5 the final sum and equality
//   compare into the output register.
//   Throughput is one point per cycle while the receiver takes each result;
//   the product stage (twelve (W+1)x(W+1) multipliers) sets the clock, not the rate.
//   Each stage holds its own valid bit and loads whenever it is empty or
//   the next stage loads, so bubbles collapse and a stalled receiver fills
//   the pipeline before in_ready drops; nothing is lost or repeated.
//   Reset (synchronous, rst_n low) empties the pipeline and sets all corners
//   to zero.
module point_in_quad_test_unit import piq_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_WIDTH-1:0]      cfg_index,
  input  logic [COORD_WIDTH-1:0]        cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_point_x,
  input  logic signed [COORD_WIDTH-1:0] in_point_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_inside_res
);

  localparam int W  = COORD_WIDTH;
  localparam int DW = W + 1;
  localparam int AW = 2 * DW + 1;
  localparam int SW = AW + 2;

  // Edge endpoints per triangle; the third vertex is the point for the
  // first four, corner 2 and corner 0 for the two quad halves.
  localparam int TRI_A [NUM_TRIS] = '{0, 1, 2, 3, 0, 2};
  localparam int TRI_B [NUM_TRIS] = '{1, 2, 3, 0, 1, 3};

  // Corner registers
  logic signed [W-1:0] cx_r [NUM_CORNERS];
  logic signed [W-1:0] cy_r [NUM_CORNERS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CORNERS; i++) begin
        cx_r[i] <= '0;
        cy_r[i] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_C0X: cx_r[0] <= cfg_wdata;
        REG_C0Y: cy_r[0] <= cfg_wdata;
        REG_C1X: cx_r[1] <= cfg_wdata;
        REG_C1Y: cy_r[1] <= cfg_wdata;
        REG_C2X: cx_r[2] <= cfg_wdata;
        REG_C2Y: cy_r[2] <= cfg_wdata;
        REG_C3X: cx_r[3] <= cfg_wdata;
        REG_C3Y: cy_r[3] <= cfg_wdata;
      endcase
    end
  end

  // Pipeline control
  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic en1, en2, en3, en4, en5;

  assign en5 = !out_valid_r || out_ready;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1) v1_r        <= in_valid;
      if (en2) v2_r        <= v1_r;
      if (en3) v3_r        <= v2_r;
      if (en4) v4_r        <= v3_r;
      if (en5) out_valid_r <= v4_r;
    end
  end

  assign in_ready  = en1;
  assign out_valid = out_valid_r;

  // Stage 1: differences and degenerate tests
  logic signed [DW-1:0] e_dx_nxt [NUM_TRIS];
  logic signed [DW-1:0] e_dy_nxt [NUM_TRIS];
  logic signed [DW-1:0] p_dx_nxt [NUM_TRIS];
  logic signed [DW-1:0] p_dy_nxt [NUM_TRIS];
  logic signed [DW-1:0] e_dx_r   [NUM_TRIS];
  logic signed [DW-1:0] e_dy_r   [NUM_TRIS];
  logic signed [DW-1:0] p_dx_r   [NUM_TRIS];
  logic signed [DW-1:0] p_dy_r   [NUM_TRIS];

  always_comb begin
    logic signed [W-1:0] tx, ty;
    for (int k = 0; k < NUM_TRIS; k++) begin
      if (k < 4) begin
        tx = in_point_x;
        ty = in_point_y;
      end else if (k == 4) begin
        tx = cx_r[2];
        ty = cy_r[2];
      end else begin
        tx = cx_r[0];
        ty = cy_r[0];
      end
      e_dx_nxt[k] = $signed({cx_r[TRI_B[k]][W-1], cx_r[TRI_B[k]]})
                  - $signed({cx_r[TRI_A[k]][W-1], cx_r[TRI_A[k]]});
      e_dy_nxt[k] = $signed({cy_r[TRI_B[k]][W-1], cy_r[TRI_B[k]]})
                  - $signed({cy_r[TRI_A[k]][W-1], cy_r[TRI_A[k]]});
      p_dx_nxt[k] = $signed({tx[W-1], tx})
                  - $signed({cx_r[TRI_A[k]][W-1], cx_r[TRI_A[k]]});
      p_dy_nxt[k] = $signed({ty[W-1], ty})
                  - $signed({cy_r[TRI_A[k]][W-1], cy_r[TRI_A[k]]});
    end
  end

  logic                same_x, same_y;
  logic signed [W-1:0] xmin, xmax, ymin, ymax;
  logic signed [W-1:0] lo_a, lo_b, hi_a, hi_b;
  logic signed [W-1:0] lo_c, lo_d, hi_c, hi_d;
  logic                deg_nxt, res_nxt;

  assign same_x = (cx_r[0] == cx_r[1]) && (cx_r[1] == cx_r[2]) && (cx_r[2] == cx_r[3]);
  assign same_y = (cy_r[0] == cy_r[1]) && (cy_r[1] == cy_r[2]) && (cy_r[2] == cy_r[3]);

  always_comb begin
    lo_a = (cy_r[0] < cy_r[1]) ? cy_r[0] : cy_r[1];
    lo_b = (cy_r[2] < cy_r[3]) ? cy_r[2] : cy_r[3];
    hi_a = (cy_r[0] > cy_r[1]) ? cy_r[0] : cy_r[1];
    hi_b = (cy_r[2] > cy_r[3]) ? cy_r[2] : cy_r[3];
    ymin = (lo_a < lo_b) ? lo_a : lo_b;
    ymax = (hi_a > hi_b) ? hi_a : hi_b;
    lo_c = (cx_r[0] < cx_r[1]) ? cx_r[0] : cx_r[1];
    lo_d = (cx_r[2] < cx_r[3]) ? cx_r[2] : cx_r[3];
    hi_c = (cx_r[0] > cx_r[1]) ? cx_r[0] : cx_r[1];
    hi_d = (cx_r[2] > cx_r[3]) ? cx_r[2] : cx_r[3];
    xmin = (lo_c < lo_d) ? lo_c : lo_d;
    xmax = (hi_c > hi_d) ? hi_c : hi_d;
  end

  always_comb begin
    deg_nxt = same_x || same_y;
    priority if (same_x && same_y) begin
      res_nxt = (in_point_x == cx_r[0]) && (in_point_y == cy_r[0]);
    end else if (same_x) begin
      res_nxt = (in_point_x == cx_r[0]) && (in_point_y >= ymin) && (in_point_y <= ymax);
    end else if (same_y) begin
      res_nxt = (in_point_y == cy_r[0]) && (in_point_x >= xmin) && (in_point_x <= xmax);
    end else begin
      res_nxt = 1'b0;
    end
  end

  logic deg1_r, deg2_r, deg3_r, deg4_r;
  logic res1_r, res2_r, res3_r, res4_r;

  always_ff @(posedge clk) begin
    if (en1) begin
      e_dx_r <= e_dx_nxt;
      e_dy_r <= e_dy_nxt;
      p_dx_r <= p_dx_nxt;
      p_dy_r <= p_dy_nxt;
      deg1_r <= deg_nxt;
      res1_r <= res_nxt;
    end
    if (en2) begin
      deg2_r <= deg1_r;
      res2_r <= res1_r;
    end
    if (en3) begin
      deg3_r <= deg2_r;
      res3_r <= res2_r;
    end
    if (en4) begin
      deg4_r <= deg3_r;
      res4_r <= res3_r;
    end
  end

  // Stages 2 and 3: triangle areas
  piq_adv_t        tri_adv;
  logic [AW-1:0]   area [NUM_TRIS];

  assign tri_adv.s2 = en2;
  assign tri_adv.s3 = en3;

  for (genvar k = 0; k < NUM_TRIS; k++) begin : g_tri
    piq_tri #(.COORD_WIDTH(COORD_WIDTH)) u_tri (
      .clk  (clk),
      .adv  (tri_adv),
      .e_dx (e_dx_r[k]),
      .p_dy (p_dy_r[k]),
      .e_dy (e_dy_r[k]),
      .p_dx (p_dx_r[k]),
      .area (area[k])
    );
  end

  // Stage 4: pairwise sums
  logic [AW:0] sum01_r, sum23_r, quad_r;

  always_ff @(posedge clk) begin
    if (en4) begin
      sum01_r <= {1'b0, area[0]} + {1'b0, area[1]};
      sum23_r <= {1'b0, area[2]} + {1'b0, area[3]};
      quad_r  <= {1'b0, area[4]} + {1'b0, area[5]};
    end
  end

  // Stage 5: total and compare
  logic [SW-1:0] total;
  logic          inside_nxt, inside_r;

  assign total      = {1'b0, sum01_r} + {1'b0, sum23_r};
  assign inside_nxt = deg4_r ? res4_r : (total == {1'b0, quad_r});

  always_ff @(posedge clk) begin
    if (en5) begin
      inside_r <= inside_nxt;
    end
  end

  assign out_inside_res = inside_r;

endmodule

// ----- rtl/core/piq_checker.sv -----
// Port-level checks for the point-in-quad test unit, bound to the top level.
// Depends only on the top level's clock, reset, handshake and result ports.
module piq_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_inside_res
);

  // A held result keeps its value until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_inside_res))
    else $error("result item changed while stalled");

  // An open output path lets every stage advance, so input must be ready.
  a_ready_open: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("in_ready low with output path open");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result item present after reset");

  // No item can reach the output after reset release before it has passed the pipeline.
  a_min_latency: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_valid ##1 !out_valid ##1 !out_valid ##1 !out_valid)
    else $error("result item appeared sooner than the pipeline depth");

endmodule

bind point_in_quad_test_unit piq_checker u_piq_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_inside_res (out_inside_res)
);
